>>> rtl/pre_pkg.sv
// Package: payload structs, codes and controller/datapath handshake types.
`default_nettype none

package pre_pkg;

    // Input command codes
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_EOF  = 1'b1;

    // Result kind codes
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_CHAR    = 2'd1;
    localparam logic [1:0] KIND_NEWLINE = 2'd2;

    // Printable range limits
    localparam logic [20:0] RUNE_SPACE = 21'h000020;
    localparam logic [20:0] RUNE_DEL   = 21'h00007F;
    localparam logic [20:0] RUNE_NBSP  = 21'h0000A0;
    localparam logic [20:0] RUNE_ERROR = 21'h00FFFD;

    localparam int          SPAN_BITS  = 6;
    localparam logic [5:0]  SPAN_RESET = 6'd6;

    typedef struct packed {
        logic        cmd;
        logic [20:0] rune_value;
        logic [2:0]  rune_bytes;
    } pre_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [39:0] offset;
        logic [20:0] out_rune;
        logic        last;
    } pre_out_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic mem_rd;
        logic emit_char;
    } pre_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;
        logic burst_start;
        logic burst_done;
    } pre_stat_t;

endpackage

`default_nettype wire

>>> rtl/printable_run_extractor_core.sv
// Top level: printable run extractor, controller plus datapath.
//
//  Channel   Signals                          Direction  Contents
//  in        in_valid / in_ready / in_data    sink       pre_in_t: cmd, rune_value, rune_bytes
//  out       out_valid / out_ready / out_data source     pre_out_t: kind, offset, out_rune, last
//  cfg       cfg_we / cfg_wdata               sink       min_span
//
// An input transaction that yields at most one result is handled without
// leaving the idle state; the result sits in the output register and the next
// transaction is taken while it waits, provided the consumer frees the register
// in the same cycle. A run that reaches min_span emits its header, then for each
// of N buffered characters a read of the single-port run buffer and a load of
// the output register. Output stalls hold the burst in place.
// Reset clears run count, pass-through flag, byte offset and sets min_span
// to 6; the run buffer needs no clearing since only entries of the current
// run are read.
`default_nettype none

module printable_run_extractor_core #(
    parameter int MAX_SPAN    = 32,
    parameter int OFFSET_BITS = 40
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cfg_we,
    input  wire [5:0]          cfg_wdata,
    input  wire                in_valid,
    output logic               in_ready,
    input  pre_pkg::pre_in_t   in_data,
    output logic               out_valid,
    input  wire                out_ready,
    output pre_pkg::pre_out_t  out_data
);

    // Command and status between sequencer and datapath
    pre_pkg::pre_cmd_t  cmd;
    pre_pkg::pre_stat_t stat;

    // Sequence acceptance and the header-plus-buffer burst
    pre_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold run state, buffer characters, drive the output register
    pre_datapath #(
        .MAX_SPAN    (MAX_SPAN),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

>>> rtl/pre_datapath.sv
// Datapath: run state, character buffer, byte offset and output register.
`default_nettype none

module pre_datapath #(
    parameter int MAX_SPAN    = 32,
    parameter int OFFSET_BITS = 40
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cfg_we,
    input  wire [5:0]             cfg_wdata,
    input  pre_pkg::pre_in_t      in_data,
    input  pre_pkg::pre_cmd_t     cmd,
    output pre_pkg::pre_stat_t    stat,
    output logic                  out_valid,
    input  wire                   out_ready,
    output pre_pkg::pre_out_t     out_data
);

    localparam int CW = $clog2(MAX_SPAN + 1);
    localparam int AW = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;

    logic [20:0]            buf_mem [MAX_SPAN];
    logic [20:0]            rd_data_reg;

    logic [5:0]             min_span_reg;
    logic [CW-1:0]          count_reg,    count_next;
    logic [CW-1:0]          total_reg,    total_next;
    logic [CW-1:0]          ptr_reg,      ptr_next;
    logic                   passing_reg,  passing_next;
    logic [OFFSET_BITS-1:0] byte_off_reg, byte_off_next;
    logic                   out_valid_reg, out_valid_next;
    pre_pkg::pre_out_t      out_data_reg,  out_data_next;

    logic                   is_eof;
    logic                   printable;
    logic [OFFSET_BITS-1:0] off_sum;
    logic [OFFSET_BITS-1:0] hdr_off;
    logic [5:0]             span_eff;
    logic [CW-1:0]          cnt_inc;
    logic                   hit;
    logic                   buf_wr;
    logic                   out_load;

    always_comb
    begin
        is_eof    = (in_data.cmd == pre_pkg::CMD_EOF);
        printable = (in_data.rune_value != pre_pkg::RUNE_ERROR) &&
                    (((in_data.rune_value >= pre_pkg::RUNE_SPACE) &&
                      (in_data.rune_value <  pre_pkg::RUNE_DEL)) ||
                     (in_data.rune_value > pre_pkg::RUNE_NBSP));
        off_sum   = byte_off_reg + OFFSET_BITS'(in_data.rune_bytes);
        if (min_span_reg == 6'd0)
            span_eff = 6'd1;
        else if (min_span_reg > 6'(MAX_SPAN))
            span_eff = 6'(MAX_SPAN);
        else
            span_eff = min_span_reg;
        hdr_off   = off_sum - OFFSET_BITS'(span_eff);
        cnt_inc   = count_reg + CW'(1);
        hit       = (6'(cnt_inc) >= span_eff);
        buf_wr    = cmd.accept && !is_eof && printable && !passing_reg;
    end

    assign stat.out_free    = !out_valid_reg || out_ready;
    assign stat.burst_start = !is_eof && printable && !passing_reg && hit;
    assign stat.burst_done  = (ptr_reg == total_reg - CW'(1));

    always_comb
    begin
        count_next    = count_reg;
        total_next    = total_reg;
        ptr_next      = ptr_reg;
        passing_next  = passing_reg;
        byte_off_next = byte_off_reg;
        out_load      = 1'b0;
        out_data_next = out_data_reg;

        if (cmd.accept)
        begin
            out_data_next.offset   = '0;
            out_data_next.out_rune = '0;
            out_data_next.last     = 1'b1;
            out_data_next.kind     = pre_pkg::KIND_NEWLINE;
            if (is_eof)
            begin
                out_load      = passing_reg;
                byte_off_next = '0;
                count_next    = '0;
                passing_next  = 1'b0;
            end
            else
            begin
                byte_off_next = off_sum;
                if (!printable)
                begin
                    out_load     = passing_reg;
                    passing_next = 1'b0;
                    count_next   = '0;
                end
                else if (passing_reg)
                begin
                    out_load               = 1'b1;
                    out_data_next.kind     = pre_pkg::KIND_CHAR;
                    out_data_next.out_rune = in_data.rune_value;
                end
                else if (hit)
                begin
                    // Run complete: header now, buffered characters follow
                    out_load             = 1'b1;
                    out_data_next.kind   = pre_pkg::KIND_HEADER;
                    out_data_next.offset = 40'(hdr_off);
                    out_data_next.last   = 1'b0;
                    count_next           = '0;
                    passing_next         = 1'b1;
                    total_next           = cnt_inc;
                    ptr_next             = '0;
                end
                else
                begin
                    count_next = cnt_inc;
                end
            end
        end
        else if (cmd.emit_char)
        begin
            out_load               = 1'b1;
            out_data_next.kind     = pre_pkg::KIND_CHAR;
            out_data_next.offset   = '0;
            out_data_next.out_rune = rd_data_reg;
            out_data_next.last     = stat.burst_done;
            ptr_next               = ptr_reg + CW'(1);
        end

        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (buf_wr)
            buf_mem[count_reg[AW-1:0]] <= in_data.rune_value;
        if (cmd.mem_rd)
            rd_data_reg <= buf_mem[ptr_reg[AW-1:0]];
        if (out_load)
            out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_span_reg  <= pre_pkg::SPAN_RESET;
            count_reg     <= '0;
            total_reg     <= '0;
            ptr_reg       <= '0;
            passing_reg   <= 1'b0;
            byte_off_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                min_span_reg <= cfg_wdata;
            count_reg     <= count_next;
            total_reg     <= total_next;
            ptr_reg       <= ptr_next;
            passing_reg   <= passing_next;
            byte_off_reg  <= byte_off_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < CW'(MAX_SPAN))
        else $error("run count reached buffer capacity");
    a_emit_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_char |-> (ptr_reg < total_reg))
        else $error("buffer read past end of run");
    a_no_write_passing: assert property (@(posedge clk) disable iff (!rst_n)
        buf_wr |-> !passing_reg)
        else $error("buffer written while passing through");
`endif

endmodule

`default_nettype wire

>>> rtl/pre_ctrl.sv
// Controller: sequences input acceptance and the buffered-character burst.
`default_nettype none

module pre_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  pre_pkg::pre_stat_t   stat,
    output pre_pkg::pre_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.accept    = 1'b0;
        cmd.mem_rd    = 1'b0;
        cmd.emit_char = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = stat.out_free;
                cmd.accept = in_valid && stat.out_free;
                if (cmd.accept && stat.burst_start)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_char = 1'b1;
                    state_next    = stat.burst_done ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef SYNTHESIS
    a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_char |-> stat.out_free)
        else $error("character emitted into a full output register");
    a_burst_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && stat.burst_start) |=> (state_reg == ST_READ))
        else $error("run completion did not start the burst");
    a_read_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_EMIT))
        else $error("buffer read not followed by emit");
`endif

endmodule

`default_nettype wire
